// ===== hw/rtl/mcc_pkg.sv =====
// ----------------------------------------------------------------------------
// mcc_pkg: shared definitions of the maze chunk carver
// Chunk geometry, memory sizes, direction and state codes, and the control
// and status bundles that pass between the carver and its random source.
// ----------------------------------------------------------------------------
`default_nettype none

package mcc_pkg;

    // Chunk geometry and stack size.
    localparam int CHUNK_WIDTH   = 32;
    localparam int CHUNK_HEIGHT  = 32;
    localparam int STACK_ENTRIES = 512;

    // Node grid: one node on every even cell in each direction.
    localparam int NODES_X = (CHUNK_WIDTH + 1) / 2;
    localparam int NODES_Y = (CHUNK_HEIGHT + 1) / 2;

    // Derived widths.
    localparam int NXW  = $clog2(NODES_X);
    localparam int NYW  = $clog2(NODES_Y);
    localparam int CXW  = $clog2(CHUNK_WIDTH);
    localparam int RW   = $clog2(CHUNK_HEIGHT);
    localparam int SAW  = $clog2(STACK_ENTRIES);
    localparam int SPW  = $clog2(STACK_ENTRIES + 1);
    localparam int ROW_W = CHUNK_WIDTH;

    // Fixed field widths of the ports.
    localparam int COORD_W   = 16;
    localparam int SEED_W    = 32;
    localparam int OUT_ROW_W = 32;
    localparam int ROW_IDX_W = 6;

    // Walk directions in their unshuffled order.
    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_LEFT  = 2'd3
    } dir_t;

    // One stack entry: a node of the grid.
    typedef struct packed {
        logic [NYW-1:0] ny;
        logic [NXW-1:0] nx;
    } node_t;

    // Sequencer states of the carver.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SEED,
        ST_POP,
        ST_SHUF,
        ST_CHK_RD,
        ST_CHK_EVAL,
        ST_WALL_RD,
        ST_WALL_WR,
        ST_PUSH_T,
        ST_PUSH_N,
        ST_CTR_RD,
        ST_CTR_WR,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } carve_state_t;

    // Seed mixing phases of the random source.
    typedef enum logic [2:0] {
        SP_READY,
        SP_MUL_X,
        SP_MUL_Y,
        SP_MUL_XY,
        SP_MUL_C3
    } seed_phase_t;

    // Control towards the random source.
    typedef struct packed {
        logic load;
        logic draw;
    } rng_ctrl_t;

    // Status from the random source.
    typedef struct packed {
        logic       ready;
        logic [1:0] pick;
    } rng_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mcc_rng.sv =====
// ----------------------------------------------------------------------------
// mcc_rng: seeded xorshift source
// Mixes the chunk coordinates with the base seed through one shared 32-bit
// multiplier, then supplies one xorshift draw per request.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_rng (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic        [mcc_pkg::SEED_W-1:0]  world_seed,
    input  logic signed [mcc_pkg::COORD_W-1:0] chunk_x,
    input  logic signed [mcc_pkg::COORD_W-1:0] chunk_y,
    input  mcc_pkg::rng_ctrl_t                 ctrl,
    output mcc_pkg::rng_stat_t                 stat
);
    import mcc_pkg::*;

    localparam logic [SEED_W-1:0] MIX_X  = 32'd73856093;
    localparam logic [SEED_W-1:0] MIX_Y  = 32'd19349663;
    localparam logic [SEED_W-1:0] MIX_XY = 32'd83492791;

    seed_phase_t        phase_reg, phase_next;
    logic [SEED_W-1:0]  rand_reg, rand_next;
    logic [SEED_W-1:0]  sx_reg, sx_next;
    logic [SEED_W-1:0]  sy_reg, sy_next;
    logic [SEED_W-1:0]  cross_reg, cross_next;
    logic [SEED_W-1:0]  mul_a, mul_b, prod;
    logic [SEED_W-1:0]  shifted;

    // One xorshift step with shifts 13, 17 and 5.
    function automatic logic [SEED_W-1:0] xorshift(input logic [SEED_W-1:0] v);
        logic [SEED_W-1:0] x;
        x = v;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

    assign shifted = xorshift(rand_reg);

    // Shared multiplier, low 32 bits of the product.
    assign prod = mul_a * mul_b;

    // Phase register and state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= SP_READY;
            rand_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            rand_reg  <= rand_next;
        end
    end

    // Operand registers.
    always_ff @(posedge clk)
    begin
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        cross_reg <= cross_next;
    end

    // Seed mixing sequence and draws.
    always_comb
    begin
        phase_next = phase_reg;
        rand_next  = rand_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        cross_next = cross_reg;
        mul_a      = sx_reg;
        mul_b      = MIX_X;
        unique case (phase_reg)
            SP_READY:
            begin
                if (ctrl.load)
                begin
                    sx_next    = {{(SEED_W-COORD_W){chunk_x[COORD_W-1]}}, chunk_x};
                    sy_next    = {{(SEED_W-COORD_W){chunk_y[COORD_W-1]}}, chunk_y};
                    rand_next  = world_seed;
                    phase_next = SP_MUL_X;
                end
                else if (ctrl.draw)
                begin
                    rand_next = shifted;
                end
            end
            SP_MUL_X:
            begin
                mul_a      = sx_reg;
                mul_b      = MIX_X;
                rand_next  = rand_reg ^ prod;
                phase_next = SP_MUL_Y;
            end
            SP_MUL_Y:
            begin
                mul_a      = sy_reg;
                mul_b      = MIX_Y;
                rand_next  = rand_reg ^ prod;
                phase_next = SP_MUL_XY;
            end
            SP_MUL_XY:
            begin
                mul_a      = sx_reg;
                mul_b      = sy_reg;
                cross_next = prod;
                phase_next = SP_MUL_C3;
            end
            SP_MUL_C3:
            begin
                mul_a      = cross_reg;
                mul_b      = MIX_XY;
                rand_next  = rand_reg ^ prod;
                phase_next = SP_READY;
            end
            default:
            begin
                phase_next = SP_READY;
            end
        endcase
    end

    assign stat.ready = (phase_reg == SP_READY);
    assign stat.pick  = shifted[1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/maze_chunk_carver.sv =====
// ----------------------------------------------------------------------------
// maze_chunk_carver: randomised depth-first maze carving of one chunk
// Seeds a xorshift source from the chunk coordinates, carves passages over
// the even-cell node grid with a backtracking stack, opens the centre cell
// and then reports the chunk one row per result, top row first.
//
//   Channel   | Signals                              | Handshake
//   ----------+--------------------------------------+---------------------------
//   command   | start, busy, chunk_x, chunk_y        | taken when start && !busy
//   config    | cfg_valid, cfg_ready, cfg_data       | taken when valid && ready
//   result    | row_strobe, row_index, row_bits,     | one-cycle strobe per row, no
//             | last_row                             | back-pressure
//
// Each stack pop is followed by four shuffle draws, a row read and an evaluation
// per direction checked, and for a carve a wall read and write when it crosses
// rows plus two pushes, all set by the single read port of the passage-row
// memory. Roughly 511 pops per chunk, then a row read and a strobe per row.
// Rows are cleared per request by per-row written flags, so no clearing pass
// is needed. Reset clears the control state and the base seed to zero.
// busy stays high from the accepted request until the last row is shown.
// ----------------------------------------------------------------------------
`default_nettype none

module maze_chunk_carver (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [mcc_pkg::COORD_W-1:0]   chunk_x,
    input  logic signed [mcc_pkg::COORD_W-1:0]   chunk_y,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [mcc_pkg::SEED_W-1:0]    cfg_data,
    output logic                                 row_strobe,
    output logic        [mcc_pkg::ROW_IDX_W-1:0] row_index,
    output logic        [mcc_pkg::OUT_ROW_W-1:0] row_bits,
    output logic                                 last_row
);
    import mcc_pkg::*;

    carve_state_t       state_reg, state_next;
    logic [SEED_W-1:0]  world_seed_reg;
    logic [SPW-1:0]     top_reg, top_next;
    logic [1:0]         shuf_idx_reg, shuf_idx_next;
    logic [1:0]         dir_idx_reg, dir_idx_next;
    dir_t               order_reg [4];
    dir_t               order_next [4];
    logic [NXW-1:0]     tx_reg, tx_next;
    logic [NYW-1:0]     ty_reg, ty_next;
    logic [RW-1:0]      emit_idx_reg, emit_idx_next;
    logic [CHUNK_HEIGHT-1:0] row_written_reg;
    logic               row_hit_reg;

    // Passage-row memory.
    logic [ROW_W-1:0]   row_mem [CHUNK_HEIGHT];
    logic [ROW_W-1:0]   row_q;
    logic               row_re, row_we, row_clear;
    logic [RW-1:0]      row_raddr, row_waddr;
    logic [ROW_W-1:0]   row_wdata, row_eff;

    // Backtracking stack memory.
    node_t              stack_mem [STACK_ENTRIES];
    node_t              stack_q;
    logic               stack_re, stack_we;
    logic [SAW-1:0]     stack_raddr, stack_waddr;
    node_t              stack_wdata;

    rng_ctrl_t          rng_ctrl;
    rng_stat_t          rng_stat;

    node_t              node;
    dir_t               cur_dir;
    logic               dir_ok;
    logic [NXW-1:0]     cand_tx;
    logic [NYW-1:0]     cand_ty;
    logic [1:0]         pick;
    logic               stack_room;

    mcc_rng u_rng (
        .clk        (clk),
        .rst_n      (rst_n),
        .world_seed (world_seed_reg),
        .chunk_x    (chunk_x),
        .chunk_y    (chunk_y),
        .ctrl       (rng_ctrl),
        .stat       (rng_stat)
    );

    // Configuration register; writes are accepted only while idle.
    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            world_seed_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            world_seed_reg <= cfg_data;
        end
    end

    // Row memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_waddr] <= row_wdata;
        end
        if (row_re)
        begin
            row_q <= row_mem[row_raddr];
        end
    end

    // Written flags per row; a row never written this request reads as walls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_written_reg <= '0;
            row_hit_reg     <= 1'b0;
        end
        else
        begin
            if (row_clear)
            begin
                row_written_reg <= '0;
            end
            if (row_we)
            begin
                row_written_reg[row_waddr] <= 1'b1;
            end
            if (row_re)
            begin
                row_hit_reg <= row_written_reg[row_raddr];
            end
        end
    end

    assign row_eff = row_hit_reg ? row_q : '0;

    // Stack memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (stack_re)
        begin
            stack_q <= stack_mem[stack_raddr];
        end
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            top_reg      <= '0;
            shuf_idx_reg <= '0;
            dir_idx_reg  <= '0;
            emit_idx_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                order_reg[i] <= DIR_UP;
            end
        end
        else
        begin
            state_reg    <= state_next;
            top_reg      <= top_next;
            shuf_idx_reg <= shuf_idx_next;
            dir_idx_reg  <= dir_idx_next;
            emit_idx_reg <= emit_idx_next;
            for (int i = 0; i < 4; i++)
            begin
                order_reg[i] <= order_next[i];
            end
        end
    end

    // Target node registers.
    always_ff @(posedge clk)
    begin
        tx_reg <= tx_next;
        ty_reg <= ty_next;
    end

    // Current node and the candidate in the direction under test.
    assign node       = stack_q;
    assign cur_dir    = order_reg[dir_idx_reg];
    assign pick       = rng_stat.pick;
    assign stack_room = (top_reg < SPW'(STACK_ENTRIES));

    always_comb
    begin
        cand_tx = node.nx;
        cand_ty = node.ny;
        dir_ok  = 1'b0;
        unique case (cur_dir)
            DIR_UP:
            begin
                dir_ok  = (node.ny != '0);
                cand_ty = node.ny - 1'b1;
            end
            DIR_RIGHT:
            begin
                dir_ok  = (node.nx != NXW'(NODES_X - 1));
                cand_tx = node.nx + 1'b1;
            end
            DIR_DOWN:
            begin
                dir_ok  = (node.ny != NYW'(NODES_Y - 1));
                cand_ty = node.ny + 1'b1;
            end
            DIR_LEFT:
            begin
                dir_ok  = (node.nx != '0);
                cand_tx = node.nx - 1'b1;
            end
            default:
            begin
                dir_ok = 1'b0;
            end
        endcase
    end

    // Next state and memory controls.
    always_comb
    begin
        state_next    = state_reg;
        top_next      = top_reg;
        shuf_idx_next = shuf_idx_reg;
        dir_idx_next  = dir_idx_reg;
        emit_idx_next = emit_idx_reg;
        tx_next       = tx_reg;
        ty_next       = ty_reg;
        for (int i = 0; i < 4; i++)
        begin
            order_next[i] = order_reg[i];
        end

        row_re      = 1'b0;
        row_raddr   = '0;
        row_we      = 1'b0;
        row_waddr   = '0;
        row_wdata   = '0;
        row_clear   = 1'b0;
        stack_re    = 1'b0;
        stack_raddr = '0;
        stack_we    = 1'b0;
        stack_waddr = '0;
        stack_wdata = '0;
        rng_ctrl    = '0;
        row_strobe  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rng_ctrl.load = 1'b1;
                    state_next    = ST_INIT;
                end
            end
            ST_INIT:
            begin
                // Fresh chunk: all walls, node zero open and on the stack.
                row_clear   = 1'b1;
                row_we      = 1'b1;
                row_waddr   = '0;
                row_wdata   = ROW_W'(1);
                stack_we    = 1'b1;
                stack_waddr = '0;
                stack_wdata = '0;
                top_next    = SPW'(1);
                state_next  = ST_SEED;
            end
            ST_SEED:
            begin
                if (rng_stat.ready)
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                if (top_reg == '0)
                begin
                    state_next = ST_CTR_RD;
                end
                else
                begin
                    stack_re      = 1'b1;
                    stack_raddr   = SAW'(top_reg - 1'b1);
                    top_next      = top_reg - 1'b1;
                    order_next[0] = DIR_UP;
                    order_next[1] = DIR_RIGHT;
                    order_next[2] = DIR_DOWN;
                    order_next[3] = DIR_LEFT;
                    shuf_idx_next = '0;
                    state_next    = ST_SHUF;
                end
            end
            ST_SHUF:
            begin
                // One draw per cycle, swapping the current slot with the pick.
                rng_ctrl.draw = 1'b1;
                order_next[shuf_idx_reg] = order_reg[pick];
                order_next[pick]         = order_reg[shuf_idx_reg];
                shuf_idx_next = shuf_idx_reg + 1'b1;
                if (shuf_idx_reg == 2'd3)
                begin
                    dir_idx_next = '0;
                    state_next   = ST_CHK_RD;
                end
            end
            ST_CHK_RD:
            begin
                if (dir_ok)
                begin
                    tx_next    = cand_tx;
                    ty_next    = cand_ty;
                    row_re     = 1'b1;
                    row_raddr  = RW'({cand_ty, 1'b0});
                    state_next = ST_CHK_EVAL;
                end
                else if (dir_idx_reg == 2'd3)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    dir_idx_next = dir_idx_reg + 1'b1;
                end
            end
            ST_CHK_EVAL:
            begin
                if (row_eff[CXW'({tx_reg, 1'b0})])
                begin
                    // Target already visited: try the next direction.
                    if (dir_idx_reg == 2'd3)
                    begin
                        state_next = ST_POP;
                    end
                    else
                    begin
                        dir_idx_next = dir_idx_reg + 1'b1;
                        state_next   = ST_CHK_RD;
                    end
                end
                else
                begin
                    // Open the target node, and the wall too when on the same row.
                    row_we    = 1'b1;
                    row_waddr = RW'({ty_reg, 1'b0});
                    row_wdata = row_eff | (ROW_W'(1) << CXW'({tx_reg, 1'b0}));
                    if (ty_reg == node.ny)
                    begin
                        row_wdata = row_wdata
                                  | (ROW_W'(1) << (CXW'(node.nx) + CXW'(tx_reg)));
                        state_next = ST_PUSH_T;
                    end
                    else
                    begin
                        state_next = ST_WALL_RD;
                    end
                end
            end
            ST_WALL_RD:
            begin
                row_re     = 1'b1;
                row_raddr  = RW'(node.ny) + RW'(ty_reg);
                state_next = ST_WALL_WR;
            end
            ST_WALL_WR:
            begin
                row_we     = 1'b1;
                row_waddr  = RW'(node.ny) + RW'(ty_reg);
                row_wdata  = row_eff | (ROW_W'(1) << CXW'({node.nx, 1'b0}));
                state_next = ST_PUSH_T;
            end
            ST_PUSH_T:
            begin
                if (stack_room)
                begin
                    stack_we       = 1'b1;
                    stack_waddr    = SAW'(top_reg);
                    stack_wdata.nx = tx_reg;
                    stack_wdata.ny = ty_reg;
                    top_next       = top_reg + 1'b1;
                end
                state_next = ST_PUSH_N;
            end
            ST_PUSH_N:
            begin
                if (stack_room)
                begin
                    stack_we    = 1'b1;
                    stack_waddr = SAW'(top_reg);
                    stack_wdata = node;
                    top_next    = top_reg + 1'b1;
                end
                state_next = ST_POP;
            end
            ST_CTR_RD:
            begin
                row_re     = 1'b1;
                row_raddr  = RW'(CHUNK_HEIGHT / 2);
                state_next = ST_CTR_WR;
            end
            ST_CTR_WR:
            begin
                row_we        = 1'b1;
                row_waddr     = RW'(CHUNK_HEIGHT / 2);
                row_wdata     = row_eff | (ROW_W'(1) << CXW'(CHUNK_WIDTH / 2));
                emit_idx_next = '0;
                state_next    = ST_EMIT_RD;
            end
            ST_EMIT_RD:
            begin
                row_re     = 1'b1;
                row_raddr  = emit_idx_reg;
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                row_strobe = 1'b1;
                if (emit_idx_reg == RW'(CHUNK_HEIGHT - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    emit_idx_next = emit_idx_reg + 1'b1;
                    state_next    = ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result and command status.
    assign busy      = (state_reg != ST_IDLE);
    assign row_index = ROW_IDX_W'(emit_idx_reg);
    assign row_bits  = OUT_ROW_W'(row_eff);
    assign last_row  = (emit_idx_reg == RW'(CHUNK_HEIGHT - 1));

endmodule

`default_nettype wire
